FILE: sv/bac_pkg.sv
// Shared types and constants of the bit-rate adaptation controller.
package bac_pkg;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_DOWN = 2'd1,
    ACT_UP   = 2'd2
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THR,
    ST_DWM,
    ST_DECIDE,
    ST_AVG,
    ST_ATT,
    ST_SFCHK,
    ST_SF,
    ST_FINISH
  } state_e;

  localparam logic [1:0] REG_LOW_WM  = 2'd0;
  localparam logic [1:0] REG_HIGH_WM = 2'd1;
  localparam logic [1:0] REG_TARGET  = 2'd2;
  localparam logic [1:0] REG_APPLY   = 2'd3;

  localparam logic [15:0] Q_0P05 = 16'd3276;
  localparam logic [15:0] Q_0P4  = 16'd26214;
  localparam logic [15:0] Q_0P6  = 16'd39321;
  localparam logic [15:0] Q_0P7  = 16'd45875;
  localparam logic [15:0] Q_0P8  = 16'd52428;

  localparam logic [30:0] STEP_DOWN            = 31'd800000;
  localparam logic [30:0] STEP_UP              = 31'd400000;
  localparam logic [30:0] STEP_UP_ABOVE_STEADY = 31'd150000;
  localparam logic [30:0] STEP_MIN             = 31'd50000;
  localparam logic [30:0] RATE_MIN             = 31'd1000000;

  localparam logic [30:0] RST_LOW_WM  = 31'd100000;
  localparam logic [30:0] RST_HIGH_WM = 31'd10000000;
  localparam logic [30:0] RST_TARGET  = 31'd5000000;
  localparam logic [30:0] RST_RATE    = 31'd5000000;

  localparam int unsigned MUL_A_W = 48;
  localparam int unsigned MUL_B_W = 16;

endpackage

FILE: sv/bac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bac_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/bitrate_adaptation_controller_core.sv
// Bit-rate adaptation controller: serial-multiply sequencer and history ring.
// Each check runs two to four shift-add multiplies, one after another.
// Throughput: one check at a time; a new beat is taken once the previous
// check has placed its result in the output register.
// Reset restores registers and rate, clears action, step and tracker; history RAM is kept.
module bitrate_adaptation_controller_core
  import bac_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH    = 32,
  parameter int unsigned STEADY_THRESHOLD = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // queue_latency[30:0], measured_rate[61:31], zero pad
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // new_bit_rate[30:0], rate_changed[31], action_taken[33:32], step_used[64:34]
  output logic [71:0] m_axis_tdata
);

  localparam int unsigned IW  = HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW  = 31 + FW;
  localparam int unsigned SCW = $clog2(STEADY_THRESHOLD + 2);

  state_e state_q, state_d;

  logic [30:0] low_wm_q, low_wm_d, high_wm_q, high_wm_d, target_q, target_d;
  logic        apply_q, apply_d;
  logic [30:0] cur_q, cur_d;
  act_e        last_q, last_d;
  logic [30:0] step_q, step_d;
  logic [SCW-1:0] steady_q, steady_d;
  logic [IW-1:0]  widx_q, widx_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [SW-1:0]  sum_q, sum_d;

  logic [30:0] lat_q, lat_d, meas_q, meas_d;
  logic [30:0] thr_q, thr_d, dwm_q, dwm_d;
  act_e        act_q, act_d;
  logic        use_sf_q, use_sf_d;
  logic [30:0] sout_q, sout_d;

  logic [MUL_A_W-1:0] mul_a_q, mul_a_d, mul_acc_q, mul_acc_d, prod;
  logic [MUL_B_W-1:0] mul_b_q, mul_b_d;
  logic [3:0]         mul_cnt_q, mul_cnt_d;
  logic               mul_done;

  logic        out_valid_q, out_valid_d;
  logic [71:0] out_data_q, out_data_d;

  logic        ram_we;
  logic [30:0] ram_rdata;

  logic signed [31:0] shortfall;
  logic               rate_act, lat_act;
  logic [30:0]        att_v, prod_q16;
  logic signed [32:0] down_v;
  logic [31:0]        up_v;
  logic [30:0]        nr;
  logic [SCW-1:0]     steady_n;

  bac_ram #(.WIDTH(31), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (cur_q),
    .raddr_i (widx_q),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign prod      = mul_acc_q + (mul_b_q[0] ? mul_a_q : '0);
  assign mul_done  = (mul_cnt_q == 4'd15);
  assign prod_q16  = prod[46:16];
  assign shortfall = $signed({1'b0, cur_q}) - $signed({1'b0, meas_q});
  assign rate_act  = shortfall > $signed({1'b0, thr_q});
  assign lat_act   = (lat_q < (low_wm_q >> 1)) || (lat_q > (high_wm_q >> 1));

  always_comb begin
    state_d     = state_q;
    low_wm_d    = low_wm_q;
    high_wm_d   = high_wm_q;
    target_d    = target_q;
    apply_d     = apply_q;
    cur_d       = cur_q;
    last_d      = last_q;
    step_d      = step_q;
    steady_d    = steady_q;
    widx_d      = widx_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    lat_d       = lat_q;
    meas_d      = meas_q;
    thr_d       = thr_q;
    dwm_d       = dwm_q;
    act_d       = act_q;
    use_sf_d    = use_sf_q;
    sout_d      = sout_q;
    mul_a_d     = mul_a_q << 1;
    mul_b_d     = mul_b_q >> 1;
    mul_acc_d   = prod;
    mul_cnt_d   = mul_cnt_q + 4'd1;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    att_v       = prod_q16;
    down_v      = '0;
    up_v        = '0;
    nr          = cur_q;
    steady_n    = steady_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          lat_d     = s_axis_tdata[30:0];
          meas_d    = s_axis_tdata[61:31];
          mul_a_d   = MUL_A_W'(cur_q);
          mul_b_d   = Q_0P05;
          mul_acc_d = '0;
          mul_cnt_d = '0;
          state_d   = ST_THR;
        end
      end
      ST_THR: begin
        if (mul_done) begin
          thr_d     = prod_q16;
          mul_a_d   = MUL_A_W'(high_wm_q);
          mul_b_d   = Q_0P4;
          mul_acc_d = '0;
          mul_cnt_d = '0;
          state_d   = ST_DWM;
        end
      end
      ST_DWM: begin
        if (mul_done) begin
          dwm_d   = prod_q16;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        use_sf_d = 1'b0;
        act_d    = ACT_NONE;
        if (rate_act || lat_act) begin
          if (rate_act && (lat_q > dwm_q)) begin
            act_d    = ACT_DOWN;
            use_sf_d = 1'b1;
          end else if (lat_q > (high_wm_q >> 1)) begin
            act_d = ACT_DOWN;
          end else if ((lat_q < low_wm_q) && (cur_q < target_q)) begin
            act_d = ACT_UP;
          end
        end
        if (act_d == ACT_NONE) begin
          last_d  = ACT_NONE;
          sout_d  = '0;
          state_d = ST_FINISH;
        end else if (act_d != last_q) begin
          last_d = act_d;
          if (act_d == ACT_DOWN) begin
            step_d  = STEP_DOWN;
            state_d = ST_SFCHK;
          end else if (fill_q != '0) begin
            mul_a_d   = MUL_A_W'(cur_q) + MUL_A_W'(STEP_UP);
            mul_b_d   = MUL_B_W'(fill_q);
            mul_acc_d = '0;
            mul_cnt_d = '0;
            state_d   = ST_AVG;
          end else begin
            step_d  = STEP_UP;
            state_d = ST_SFCHK;
          end
        end else begin
          mul_a_d   = MUL_A_W'(step_q);
          mul_b_d   = (act_d == ACT_DOWN) ? Q_0P6 : Q_0P7;
          mul_acc_d = '0;
          mul_cnt_d = '0;
          state_d   = ST_ATT;
        end
      end
      ST_AVG: begin
        if (mul_done) begin
          if ((MUL_A_W'(sum_q) >= MUL_A_W'(fill_q)) && (MUL_A_W'(sum_q) < prod)) begin
            step_d = STEP_UP_ABOVE_STEADY;
          end else begin
            step_d = STEP_UP;
          end
          state_d = ST_SFCHK;
        end
      end
      ST_ATT: begin
        if (mul_done) begin
          step_d  = (att_v < STEP_MIN) ? STEP_MIN : att_v;
          state_d = ST_SFCHK;
        end
      end
      ST_SFCHK: begin
        if (use_sf_q && ($signed({1'b0, step_q}) < shortfall)) begin
          mul_a_d   = MUL_A_W'(shortfall[30:0]);
          mul_b_d   = Q_0P8;
          mul_acc_d = '0;
          mul_cnt_d = '0;
          state_d   = ST_SF;
        end else begin
          sout_d  = step_q;
          state_d = ST_FINISH;
        end
      end
      ST_SF: begin
        if (mul_done) begin
          sout_d  = prod_q16;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          down_v = $signed({2'b0, cur_q}) - $signed({2'b0, sout_q});
          up_v   = {1'b0, cur_q} + {1'b0, sout_q};
          case (last_q)
            ACT_DOWN: nr = (down_v < $signed({2'b0, RATE_MIN})) ? RATE_MIN : down_v[30:0];
            ACT_UP:   nr = (up_v > {1'b0, target_q}) ? target_q : up_v[30:0];
            default:  nr = cur_q;
          endcase
          if (last_q != ACT_NONE) begin
            steady_d = '0;
          end else begin
            if (steady_q <= SCW'(STEADY_THRESHOLD)) begin
              steady_n = steady_q + SCW'(1);
            end
            steady_d = steady_n;
            if (steady_n > SCW'(STEADY_THRESHOLD)) begin
              ram_we = 1'b1;
              widx_d = (widx_q == IW'(HISTORY_DEPTH - 1)) ? '0 : widx_q + IW'(1);
              if (fill_q == FW'(HISTORY_DEPTH)) begin
                sum_d = sum_q - SW'(ram_rdata) + SW'(cur_q);
              end else begin
                fill_d = fill_q + FW'(1);
                sum_d  = sum_q + SW'(cur_q);
              end
            end
          end
          if (apply_q && (nr != cur_q)) begin
            cur_d = nr;
          end
          out_data_d  = {7'b0, sout_q, last_q, apply_q && (nr != cur_q), nr};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LOW_WM, REG_HIGH_WM: begin
          if (cfg_addr_i == REG_LOW_WM) begin
            low_wm_d = cfg_wdata_i;
          end else begin
            high_wm_d = cfg_wdata_i;
          end
          last_d   = ACT_NONE;
          step_d   = '0;
          steady_d = '0;
          widx_d   = '0;
          fill_d   = '0;
          sum_d    = '0;
        end
        REG_TARGET: target_d = cfg_wdata_i;
        REG_APPLY:  apply_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      low_wm_q    <= RST_LOW_WM;
      high_wm_q   <= RST_HIGH_WM;
      target_q    <= RST_TARGET;
      apply_q     <= 1'b1;
      cur_q       <= RST_RATE;
      last_q      <= ACT_NONE;
      step_q      <= '0;
      steady_q    <= '0;
      widx_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_wm_q    <= low_wm_d;
      high_wm_q   <= high_wm_d;
      target_q    <= target_d;
      apply_q     <= apply_d;
      cur_q       <= cur_d;
      last_q      <= last_d;
      step_q      <= step_d;
      steady_q    <= steady_d;
      widx_q      <= widx_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lat_q      <= lat_d;
    meas_q     <= meas_d;
    thr_q      <= thr_d;
    dwm_q      <= dwm_d;
    act_q      <= act_d;
    use_sf_q   <= use_sf_d;
    sout_q     <= sout_d;
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    mul_acc_q  <= mul_acc_d;
    mul_cnt_q  <= mul_cnt_d;
    out_data_q <= out_data_d;
  end

endmodule

FILE: sv/bac_checker.sv
// Port-level checker of the bit-rate adaptation controller and its bind.
module bac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
    else $error("illegal action code");

  a_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33:32] == 2'd0 |-> m_axis_tdata[64:34] == 31'd0)
    else $error("step reported without action");

  a_down_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33:32] == 2'd1 |-> m_axis_tdata[30:0] >= 31'd1000000)
    else $error("downgrade below rate floor");

endmodule

bind bitrate_adaptation_controller_core bac_checker u_bac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
